>>> hdl/point_segment_ccd_safe_step_defines.svh
// assertion macros used by the checker file
`ifndef POINT_SEGMENT_CCD_SAFE_STEP_DEFINES_SVH
`define POINT_SEGMENT_CCD_SAFE_STEP_DEFINES_SVH

// same-cycle implication on the rising clock edge
`define PSC_ASSERT_IMP(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("psc property violated");

// next-cycle implication on the rising clock edge
`define PSC_ASSERT_NXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("psc property violated");

`endif

>>> hdl/psc_pkg.sv
// shared constants and types of the point-segment collision step
package psc_pkg;

    localparam int P_COORD_WIDTH = 32;
    localparam int TIME_BITS     = 16;
    localparam int TIME_W        = TIME_BITS + 1;
    localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(1) << TIME_BITS;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int EPS_W      = 32;

    localparam logic [TIME_W-1:0] STEP_FRACTION_RST = TIME_W'(58982);
    localparam logic [EPS_W-1:0]  EPS_RST           = EPS_W'(1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEP_FRACTION,
        REG_EPS_THRESHOLD
    } t_cfg_reg;

endpackage

>>> hdl/psc_mul.sv
// two-stage unsigned multiplier lanes built from half-width partial products
module psc_mul #(
    parameter int N     = 68,
    parameter int LANES = 2,
    parameter int SBW   = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [LANES-1:0][N-1:0]     i_a,
    input  logic [LANES-1:0][N-1:0]     i_b,
    input  logic [SBW-1:0]              i_sb,
    output logic                        o_vld,
    output logic [LANES-1:0][2*N-1:0]   o_p,
    output logic [SBW-1:0]              o_sb
);
    localparam int H = (N + 1) / 2;
    localparam int L = N - H;

    logic [LANES-1:0][2*H-1:0] r_ll;
    logic [LANES-1:0][N-1:0]   r_lh;
    logic [LANES-1:0][N-1:0]   r_hl;
    logic [LANES-1:0][2*L-1:0] r_hh;
    logic                      r_vld1;
    logic [SBW-1:0]            r_sb1;
    logic [LANES-1:0][2*N-1:0] r_p;
    logic                      r_vld2;
    logic [SBW-1:0]            r_sb2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // partial products, then the recombining add
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            r_ll[k] <= i_a[k][H-1:0] * i_b[k][H-1:0];
            r_lh[k] <= i_a[k][H-1:0] * i_b[k][N-1:H];
            r_hl[k] <= i_a[k][N-1:H] * i_b[k][H-1:0];
            r_hh[k] <= i_a[k][N-1:H] * i_b[k][N-1:H];
            r_p[k]  <= ((2*N)'(r_hh[k]) << (2 * H))
                     + (((2*N)'(r_lh[k]) + (2*N)'(r_hl[k])) << H)
                     + (2*N)'(r_ll[k]);
        end
        r_sb1 <= i_sb;
        r_sb2 <= r_sb1;
    end

    assign o_vld = r_vld2;
    assign o_p   = r_p;
    assign o_sb  = r_sb2;

endmodule

>>> hdl/psc_div.sv
// pipelined ratio lanes: accept n/d in [0,1] and give its Q1.16 quotient, one bit a stage
module psc_div #(
    parameter int NW    = 71,
    parameter int TW    = 17,
    parameter int LANES = 2,
    parameter int SBW   = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [LANES-1:0][NW-1:0]  i_n,
    input  logic [LANES-1:0][NW-1:0]  i_d,
    input  logic [SBW-1:0]            i_sb,
    output logic                      o_vld,
    output logic [LANES-1:0]          o_ok,
    output logic [LANES-1:0][TW-1:0]  o_q,
    output logic [SBW-1:0]            o_sb
);
    localparam int RMD = NW + 1;

    logic [LANES-1:0][RMD-1:0] r_rem [0:TW];
    logic [LANES-1:0][NW-1:0]  r_den [0:TW];
    logic [LANES-1:0][TW-1:0]  r_q   [0:TW];
    logic [LANES-1:0]          r_ok  [0:TW];
    logic                      r_vld [0:TW];
    logic [SBW-1:0]            r_sb  [0:TW];

    logic [LANES-1:0][NW-1:0]  nn;
    logic [LANES-1:0][NW-1:0]  dd;
    logic [LANES-1:0]          n_ok;

    // sign normalize and range check
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            nn[k]   = i_d[k][NW-1] ? NW'(-$signed(i_n[k])) : i_n[k];
            dd[k]   = i_d[k][NW-1] ? NW'(-$signed(i_d[k])) : i_d[k];
            n_ok[k] = (i_d[k] != '0) && !nn[k][NW-1] && !($signed(nn[k]) > $signed(dd[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            r_rem[0][k] <= RMD'(nn[k]);
            r_den[0][k] <= dd[k];
            r_q[0][k]   <= '0;
        end
        r_ok[0] <= n_ok;
        r_sb[0] <= i_sb;
    end

    for (genvar g = 0; g < TW; g++) begin : g_step
        logic [LANES-1:0][RMD-1:0] remsh;
        logic [LANES-1:0]          ge;

        always_comb begin
            for (int k = 0; k < LANES; k++) begin
                // the integer bit needs no shift, fraction bits do
                remsh[k] = (g == 0) ? r_rem[g][k] : (r_rem[g][k] << 1);
                ge[k]    = remsh[k] >= RMD'(r_den[g][k]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int k = 0; k < LANES; k++) begin
                r_rem[g+1][k] <= ge[k] ? RMD'(remsh[k] - RMD'(r_den[g][k])) : remsh[k];
                r_den[g+1][k] <= r_den[g][k];
                r_q[g+1][k]   <= {r_q[g][k][TW-2:0], ge[k]};
            end
            r_ok[g+1] <= r_ok[g];
            r_sb[g+1] <= r_sb[g];
        end
    end

    assign o_vld = r_vld[TW];
    assign o_ok  = r_ok[TW];
    assign o_q   = r_q[TW];
    assign o_sb  = r_sb[TW];

endmodule

>>> hdl/point_segment_ccd_safe_step.sv
// throughput: one item every cycle, busy never rises; the stage count is set by the
//   bit-per-stage square root (2*COORD_WIDTH + 5 stages) and the 17-stage ratio divider
// reset: synchronous active-low clears every stage valid and loads the register defaults
// the result is shown for one cycle with o_done; the receiver cannot hold it off
module point_segment_ccd_safe_step #(
    parameter int COORD_WIDTH = psc_pkg::P_COORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [psc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [psc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic signed [COORD_WIDTH-1:0]     i_point_x,
    input  logic signed [COORD_WIDTH-1:0]     i_point_y,
    input  logic signed [COORD_WIDTH-1:0]     i_point_dx,
    input  logic signed [COORD_WIDTH-1:0]     i_point_dy,
    input  logic signed [COORD_WIDTH-1:0]     i_seg_a_x,
    input  logic signed [COORD_WIDTH-1:0]     i_seg_a_y,
    input  logic signed [COORD_WIDTH-1:0]     i_seg_a_dx,
    input  logic signed [COORD_WIDTH-1:0]     i_seg_a_dy,
    input  logic signed [COORD_WIDTH-1:0]     i_seg_b_x,
    input  logic signed [COORD_WIDTH-1:0]     i_seg_b_y,
    input  logic signed [COORD_WIDTH-1:0]     i_seg_b_dx,
    input  logic signed [COORD_WIDTH-1:0]     i_seg_b_dy,
    output logic                              o_done,
    output logic                              o_hit,
    output logic [psc_pkg::TIME_W-1:0]        o_impact_time,
    output logic [psc_pkg::TIME_W-1:0]        o_safe_step
);
    import psc_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;              // relative coordinates
    localparam int PRW  = 2 * DW;             // cross product terms
    localparam int CW   = PRW + 2;            // quadratic coefficients
    localparam int DXW  = 2 * CW + 3;         // signed discriminant
    localparam int SQW  = 2 * CW + 2;         // discriminant fed to the root
    localparam int RW   = SQW / 2;            // root bits, one stage each
    localparam int RMW  = RW + 2;             // root remainder
    localparam int NW   = CW + 3;             // ratio operands
    localparam int TW   = TIME_W;
    localparam int PPW  = DW + TW + 1;        // displacement times time
    localparam int PW   = DW + TW + 2;        // positions at impact time
    localparam int LW   = 2 * PW + 1;         // squared length
    localparam int DTW  = 2 * PW + 2;         // signed dot product
    localparam int DFW  = 8 * DW;
    localparam int SBM  = 3 * CW + 3 + DFW;   // coefficients, flags, relative terms
    localparam int SBD  = 2 + DFW;
    localparam int SBP  = TW + 3;

    // relative term slots
    localparam int X21X = 0;
    localparam int X21Y = 1;
    localparam int X32X = 2;
    localparam int X32Y = 3;
    localparam int D21X = 4;
    localparam int D21Y = 5;
    localparam int D32X = 6;
    localparam int D32Y = 7;

    // ---------------- configuration registers ----------------
    logic [TW-1:0]    r_step_fraction;
    logic [EPS_W-1:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_fraction <= STEP_FRACTION_RST;
            r_eps           <= EPS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_STEP_FRACTION: r_step_fraction <= i_cfg_wdata[TW-1:0];
                REG_EPS_THRESHOLD: r_eps <= i_cfg_wdata[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline never stalls, so an item is taken on every start
    assign o_busy = 1'b0;

    // ---------------- s0: capture the item ----------------
    logic                 r_s0_vld;
    logic [W-1:0]         r_in [0:11];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in[0]  <= i_point_x;
        r_in[1]  <= i_point_y;
        r_in[2]  <= i_point_dx;
        r_in[3]  <= i_point_dy;
        r_in[4]  <= i_seg_a_x;
        r_in[5]  <= i_seg_a_y;
        r_in[6]  <= i_seg_a_dx;
        r_in[7]  <= i_seg_a_dy;
        r_in[8]  <= i_seg_b_x;
        r_in[9]  <= i_seg_b_y;
        r_in[10] <= i_seg_b_dx;
        r_in[11] <= i_seg_b_dy;
    end

    // ---------------- s1: positions and motion relative to endpoint a ----------------
    logic                  r_s1_vld;
    logic [7:0][DW-1:0]    r_s1_df;
    logic [7:0][DW-1:0]    n_s1_df;

    function automatic logic [DW-1:0] rel(input logic [W-1:0] u, input logic [W-1:0] v);
        rel = DW'($signed({u[W-1], u}) - $signed({v[W-1], v}));
    endfunction

    always_comb begin
        n_s1_df[X21X] = rel(r_in[0], r_in[4]);
        n_s1_df[X21Y] = rel(r_in[1], r_in[5]);
        n_s1_df[X32X] = rel(r_in[8], r_in[4]);
        n_s1_df[X32Y] = rel(r_in[9], r_in[5]);
        n_s1_df[D21X] = rel(r_in[2], r_in[6]);
        n_s1_df[D21Y] = rel(r_in[3], r_in[7]);
        n_s1_df[D32X] = rel(r_in[10], r_in[6]);
        n_s1_df[D32Y] = rel(r_in[11], r_in[7]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_df <= n_s1_df;
    end

    // ---------------- s2: cross product terms ----------------
    logic                  r_s2_vld;
    logic signed [PRW-1:0] r_s2_pr [0:7];
    logic [7:0][DW-1:0]    r_s2_df;

    function automatic logic signed [PRW-1:0] smul(input logic [DW-1:0] u,
                                                   input logic [DW-1:0] v);
        smul = $signed(u) * $signed(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // a: d32 x d21, b: d32 x x21 + x32 x d21, c: x32 x x21
        r_s2_pr[0] <= smul(r_s1_df[D32X], r_s1_df[D21Y]);
        r_s2_pr[1] <= smul(r_s1_df[D32Y], r_s1_df[D21X]);
        r_s2_pr[2] <= smul(r_s1_df[D32X], r_s1_df[X21Y]);
        r_s2_pr[3] <= smul(r_s1_df[D32Y], r_s1_df[X21X]);
        r_s2_pr[4] <= smul(r_s1_df[X32X], r_s1_df[D21Y]);
        r_s2_pr[5] <= smul(r_s1_df[X32Y], r_s1_df[D21X]);
        r_s2_pr[6] <= smul(r_s1_df[X32X], r_s1_df[X21Y]);
        r_s2_pr[7] <= smul(r_s1_df[X32Y], r_s1_df[X21X]);
        r_s2_df    <= r_s1_df;
    end

    // ---------------- s3: quadratic coefficients ----------------
    logic                  r_s3_vld;
    logic signed [CW-1:0]  r_s3_a;
    logic signed [CW-1:0]  r_s3_b;
    logic signed [CW-1:0]  r_s3_c;
    logic [7:0][DW-1:0]    r_s3_df;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_a  <= CW'(r_s2_pr[0]) - CW'(r_s2_pr[1]);
        r_s3_b  <= CW'(r_s2_pr[2]) - CW'(r_s2_pr[3]) + CW'(r_s2_pr[4]) - CW'(r_s2_pr[5]);
        r_s3_c  <= CW'(r_s2_pr[6]) - CW'(r_s2_pr[7]);
        r_s3_df <= r_s2_df;
    end

    // ---------------- s4: magnitudes and near-zero flags ----------------
    logic                    r_s4_vld;
    logic [1:0][CW-1:0]      r_s4_ma;
    logic [1:0][CW-1:0]      r_s4_mb;
    logic [SBM-1:0]          r_s4_sb;
    logic [CW-1:0]           n_mag_a;
    logic [CW-1:0]           n_mag_b;
    logic [CW-1:0]           n_mag_c;
    logic                    n_lin;
    logic                    n_bsm;

    always_comb begin
        n_mag_a = r_s3_a[CW-1] ? CW'(-r_s3_a) : CW'(r_s3_a);
        n_mag_b = r_s3_b[CW-1] ? CW'(-r_s3_b) : CW'(r_s3_b);
        n_mag_c = r_s3_c[CW-1] ? CW'(-r_s3_c) : CW'(r_s3_c);
        n_lin   = n_mag_a < CW'(r_eps);
        n_bsm   = n_mag_b < CW'(r_eps);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // lane 0 squares b, lane 1 forms |a c|
        r_s4_ma[0] <= n_mag_b;
        r_s4_mb[0] <= n_mag_b;
        r_s4_ma[1] <= n_mag_a;
        r_s4_mb[1] <= n_mag_c;
        r_s4_sb    <= {r_s3_a, r_s3_b, r_s3_c, r_s3_a[CW-1] ^ r_s3_c[CW-1],
                       n_lin, n_bsm, r_s3_df};
    end

    logic                   m_vld;
    logic [1:0][2*CW-1:0]   m_p;
    logic [SBM-1:0]         m_sb;

    psc_mul #(
        .N     (CW),
        .LANES (2),
        .SBW   (SBM)
    ) u_disc_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s4_vld),
        .i_a     (r_s4_ma),
        .i_b     (r_s4_mb),
        .i_sb    (r_s4_sb),
        .o_vld   (m_vld),
        .o_p     (m_p),
        .o_sb    (m_sb)
    );

    // ---------------- s7: discriminant b^2 - 4ac ----------------
    logic [DXW-1:0] n_disc;
    logic           m_sac;

    assign m_sac = m_sb[DFW+2];

    always_comb begin
        if (m_sac) begin
            n_disc = DXW'(m_p[0]) + (DXW'(m_p[1]) << 2);
        end else begin
            n_disc = DXW'(m_p[0]) - (DXW'(m_p[1]) << 2);
        end
    end

    // bit-serial square root, stage 0 holds the discriminant
    logic [RMW-1:0] r_sq_rem  [0:RW];
    logic [RW-1:0]  r_sq_root [0:RW];
    logic [SQW-1:0] r_sq_d    [0:RW];
    logic           r_sq_vld  [0:RW];
    logic [SBM-1:0] r_sq_sb   [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else begin
            r_sq_vld[0] <= m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_d[0]    <= n_disc[SQW-1:0];
        // negative discriminant flag takes the slot of the product sign
        r_sq_sb[0]   <= {m_sb[SBM-1:DFW+3], n_disc[DXW-1], m_sb[DFW+1:0]};
    end

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        logic [RMW+1:0] remsh;
        logic [RMW+1:0] trial;
        logic           ge;

        always_comb begin
            remsh = {r_sq_rem[g], r_sq_d[g][SQW-1 -: 2]};
            trial = (RMW+2)'({r_sq_root[g], 2'b01});
            ge    = remsh >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[g+1] <= 1'b0;
            end else begin
                r_sq_vld[g+1] <= r_sq_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_rem[g+1]  <= ge ? RMW'(remsh - trial) : RMW'(remsh);
            r_sq_root[g+1] <= {r_sq_root[g][RW-2:0], ge};
            r_sq_d[g+1]    <= r_sq_d[g] << 2;
            r_sq_sb[g+1]   <= r_sq_sb[g];
        end
    end

    // ---------------- stable root form and ratio operands ----------------
    logic [SBM-1:0]        s_sb;
    logic signed [CW-1:0]  s_a;
    logic signed [CW-1:0]  s_b;
    logic signed [CW-1:0]  s_c;
    logic                  s_neg;
    logic                  s_lin;
    logic                  s_bsm;
    logic signed [NW-1:0]  s_r;
    logic signed [NW-1:0]  n_q2;

    assign s_sb  = r_sq_sb[RW];
    assign s_a   = s_sb[DFW+3+2*CW +: CW];
    assign s_b   = s_sb[DFW+3+CW +: CW];
    assign s_c   = s_sb[DFW+3 +: CW];
    assign s_neg = s_sb[DFW+2];
    assign s_lin = s_sb[DFW+1];
    assign s_bsm = s_sb[DFW];
    assign s_r   = $signed(NW'(r_sq_root[RW]));

    // q2 = -(b + sign(b) r)
    always_comb begin
        if (s_b[CW-1]) begin
            n_q2 = s_r - NW'(s_b);
        end else begin
            n_q2 = -(NW'(s_b) + s_r);
        end
    end

    logic                   r_dv_vld;
    logic [1:0][NW-1:0]     r_dv_n;
    logic [1:0][NW-1:0]     r_dv_d;
    logic [SBD-1:0]         r_dv_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= 1'b0;
        end else begin
            r_dv_vld <= r_sq_vld[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        // lane 0: -c/b in the linear case, q2/2a otherwise; lane 1: 2c/q2
        r_dv_n[0] <= s_lin ? NW'(-NW'(s_c)) : NW'(n_q2);
        r_dv_d[0] <= s_lin ? NW'(s_b) : NW'(NW'(s_a) <<< 1);
        r_dv_n[1] <= NW'(NW'(s_c) <<< 1);
        r_dv_d[1] <= NW'(n_q2);
        r_dv_sb   <= {(s_lin && !s_bsm) || (!s_lin && !s_neg), !s_lin && !s_neg,
                      s_sb[DFW-1:0]};
    end

    logic                  v_vld;
    logic [1:0]            v_ok;
    logic [1:0][TW-1:0]    v_q;
    logic [SBD-1:0]        v_sb;

    psc_div #(
        .NW    (NW),
        .TW    (TW),
        .LANES (2),
        .SBW   (SBD)
    ) u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_dv_vld),
        .i_n     (r_dv_n),
        .i_d     (r_dv_d),
        .i_sb    (r_dv_sb),
        .o_vld   (v_vld),
        .o_ok    (v_ok),
        .o_q     (v_q),
        .o_sb    (v_sb)
    );

    // ---------------- earliest accepted root ----------------
    logic                 r_sel_vld;
    logic                 r_sel_fnd;
    logic [TW-1:0]        r_sel_tq;
    logic [7:0][DW-1:0]   r_sel_df;
    logic                 n_v1;
    logic                 n_v2;

    assign n_v1 = v_ok[0] && v_sb[DFW+1];
    assign n_v2 = v_ok[1] && v_sb[DFW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_vld <= 1'b0;
        end else begin
            r_sel_vld <= v_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel_fnd <= n_v1 || n_v2;
        if (n_v1 && (!n_v2 || v_q[0] < v_q[1])) begin
            r_sel_tq <= v_q[0];
        end else begin
            r_sel_tq <= v_q[1];
        end
        r_sel_df <= v_sb[DFW-1:0];
    end

    // ---------------- p1: motion scaled by the impact time ----------------
    logic                  r_p1_vld;
    logic signed [PPW-1:0] r_p1_pp [0:3];
    logic [DW-1:0]         r_p1_x  [0:3];
    logic                  r_p1_fnd;
    logic [TW-1:0]         r_p1_tq;
    logic signed [TW:0]    sel_t;

    assign sel_t = $signed({1'b0, r_sel_tq});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= r_sel_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // slots: rel x, rel y, seg x, seg y
        r_p1_pp[0] <= $signed(r_sel_df[D21X]) * sel_t;
        r_p1_pp[1] <= $signed(r_sel_df[D21Y]) * sel_t;
        r_p1_pp[2] <= $signed(r_sel_df[D32X]) * sel_t;
        r_p1_pp[3] <= $signed(r_sel_df[D32Y]) * sel_t;
        r_p1_x[0]  <= r_sel_df[X21X];
        r_p1_x[1]  <= r_sel_df[X21Y];
        r_p1_x[2]  <= r_sel_df[X32X];
        r_p1_x[3]  <= r_sel_df[X32Y];
        r_p1_fnd   <= r_sel_fnd;
        r_p1_tq    <= r_sel_tq;
    end

    // ---------------- p2: positions at impact ----------------
    logic                 r_p2_vld;
    logic signed [PW-1:0] r_p2_v [0:3];
    logic                 r_p2_fnd;
    logic [TW-1:0]        r_p2_tq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_p2_v[k] <= (PW'($signed(r_p1_x[k])) <<< TIME_BITS) + PW'(r_p1_pp[k]);
        end
        r_p2_fnd <= r_p1_fnd;
        r_p2_tq  <= r_p1_tq;
    end

    // ---------------- p3: magnitudes into the product lanes ----------------
    logic                r_p3_vld;
    logic [3:0][PW-1:0]  r_p3_a;
    logic [3:0][PW-1:0]  r_p3_b;
    logic [SBP-1:0]      r_p3_sb;
    logic [PW-1:0]       p_mag [0:3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            p_mag[k] = r_p2_v[k][PW-1] ? PW'(-r_p2_v[k]) : PW'(r_p2_v[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else begin
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // lanes: sx*sx, sy*sy, rx*sx, ry*sy
        r_p3_a[0] <= p_mag[2];
        r_p3_b[0] <= p_mag[2];
        r_p3_a[1] <= p_mag[3];
        r_p3_b[1] <= p_mag[3];
        r_p3_a[2] <= p_mag[0];
        r_p3_b[2] <= p_mag[2];
        r_p3_a[3] <= p_mag[1];
        r_p3_b[3] <= p_mag[3];
        r_p3_sb   <= {r_p2_fnd, r_p2_tq, r_p2_v[0][PW-1] ^ r_p2_v[2][PW-1],
                      r_p2_v[1][PW-1] ^ r_p2_v[3][PW-1]};
    end

    logic                 q_vld;
    logic [3:0][2*PW-1:0] q_p;
    logic [SBP-1:0]       q_sb;

    psc_mul #(
        .N     (PW),
        .LANES (4),
        .SBW   (SBP)
    ) u_inside_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p3_vld),
        .i_a     (r_p3_a),
        .i_b     (r_p3_b),
        .i_sb    (r_p3_sb),
        .o_vld   (q_vld),
        .o_p     (q_p),
        .o_sb    (q_sb)
    );

    // ---------------- p4: squared length and projection ----------------
    logic                  r_p4_vld;
    logic [LW-1:0]         r_p4_len;
    logic signed [DTW-1:0] r_p4_dot;
    logic                  r_p4_fnd;
    logic [TW-1:0]         r_p4_tq;
    logic signed [DTW-1:0] t_rs;
    logic signed [DTW-1:0] t_ry;

    always_comb begin
        t_rs = $signed(DTW'(q_p[2]));
        t_ry = $signed(DTW'(q_p[3]));
        if (q_sb[1]) begin
            t_rs = -t_rs;
        end
        if (q_sb[0]) begin
            t_ry = -t_ry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_vld <= 1'b0;
        end else begin
            r_p4_vld <= q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p4_len <= LW'(q_p[0]) + LW'(q_p[1]);
        r_p4_dot <= t_rs + t_ry;
        r_p4_fnd <= q_sb[SBP-1];
        r_p4_tq  <= q_sb[2 +: TW];
    end

    // ---------------- p5: contact must lie on a real segment ----------------
    logic          r_p5_vld;
    logic          r_p5_hit;
    logic [TW-1:0] r_p5_tq;
    logic          n_degen;
    logic          n_outside;

    always_comb begin
        n_degen   = (r_p4_len == '0) || (r_p4_len < (LW'(r_eps) << (2 * TIME_BITS)));
        n_outside = r_p4_dot[DTW-1] || (r_p4_dot > $signed({1'b0, r_p4_len}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_vld <= 1'b0;
        end else begin
            r_p5_vld <= r_p4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p5_hit <= r_p4_fnd && !n_degen && !n_outside;
        r_p5_tq  <= r_p4_tq;
    end

    // ---------------- f1: eta times impact time ----------------
    logic            r_f1_vld;
    logic            r_f1_hit;
    logic [TW-1:0]   r_f1_tq;
    logic [2*TW-1:0] r_f1_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else begin
            r_f1_vld <= r_p5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_prod <= r_step_fraction * r_p5_tq;
        r_f1_hit  <= r_p5_hit;
        r_f1_tq   <= r_p5_tq;
    end

    // ---------------- f2: result register ----------------
    logic                     r_out_vld;
    logic                     r_out_hit;
    logic [TW-1:0]            r_out_time;
    logic [TW-1:0]            r_out_safe;
    logic [2*TW-TIME_BITS-1:0] f_scaled;

    assign f_scaled = r_f1_prod[2*TW-1:TIME_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hit <= r_f1_hit;
        if (!r_f1_hit) begin
            // no contact: full step allowed
            r_out_time <= '0;
            r_out_safe <= TIME_ONE;
        end else begin
            r_out_time <= r_f1_tq;
            if (r_f1_tq == '0) begin
                r_out_safe <= '0;
            end else if (f_scaled > (2*TW-TIME_BITS)'(TIME_ONE)) begin
                // factor above one saturates at a full step
                r_out_safe <= TIME_ONE;
            end else begin
                r_out_safe <= f_scaled[TW-1:0];
            end
        end
    end

    assign o_done        = r_out_vld;
    assign o_hit         = r_out_hit;
    assign o_impact_time = r_out_time;
    assign o_safe_step   = r_out_safe;

endmodule

>>> hdl/psc_checker.sv
// port-level checker for the point-segment collision step, bound to the top level
`include "point_segment_ccd_safe_step_defines.svh"

module psc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_done,
    input logic                        o_hit,
    input logic [psc_pkg::TIME_W-1:0]  o_impact_time,
    input logic [psc_pkg::TIME_W-1:0]  o_safe_step
);
    import psc_pkg::*;

    // a miss gives zero time and a full step
    `PSC_ASSERT_IMP(a_miss_values, i_clk, !i_rst_n, o_done && !o_hit, o_impact_time == '0 && o_safe_step == TIME_ONE)
    // contact at the start allows no motion
    `PSC_ASSERT_IMP(a_zero_time, i_clk, !i_rst_n, o_done && o_hit && o_impact_time == '0, o_safe_step == '0)
    // times stay within one step
    `PSC_ASSERT_IMP(a_time_range, i_clk, !i_rst_n, o_done && o_hit, o_impact_time <= TIME_ONE && o_safe_step <= TIME_ONE)
    // reset flushes the pipeline
    `PSC_ASSERT_NXT(a_reset_quiet, i_clk, 1'b0, !i_rst_n, !o_done)

endmodule

bind point_segment_ccd_safe_step psc_checker u_psc_checker (.*);
